// File: design/tcsm_pkg.sv
// Shared constants for the task CPU share monitor.
// No dependencies; imported by the divider, the monitor and the testbench.
package tcsm_pkg;

  // Default sizing of the task table and the tick timer
  localparam int unsigned MAX_TASKS_DEF   = 16;
  localparam int unsigned TIMER_WIDTH_DEF = 24;

  // Field widths fixed by the interface
  localparam int unsigned TASK_W   = 4;
  localparam int unsigned TVAL_W   = 24;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned SHARE_W  = 7;
  localparam int unsigned BUSY_W   = 32;
  localparam int unsigned RELOAD_W = 25;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Shared divider: 33-bit dividend (count plus half reload), 25-bit divisor
  localparam int unsigned DIVD_W    = BUSY_W + 1;
  localparam int unsigned DIVS_W    = RELOAD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIVD_W);

  localparam logic [SHARE_W-1:0] PCT_FULL = 7'd100;

  // Divider handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

endpackage

// File: design/tcsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tcsm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tcsm_pkg for its widths and the request struct.
module tcsm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  tcsm_pkg::div_req_t             req,
  output logic                           done,
  output logic [tcsm_pkg::DIVD_W-1:0]    quotient
);
  import tcsm_pkg::*;

  logic                 running;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVS_W-1:0]    rem;
  logic [DIVS_W:0]      rem_sh;
  logic                 ge;
  logic [DIVS_W:0]      rem_sub;

  always_comb begin
    rem_sh  = {rem, quotient[DIVD_W-1]};
    ge      = rem_sh >= {1'b0, req.divisor};
    rem_sub = rem_sh - {1'b0, req.divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && cnt == DIV_CNT_W'(DIVD_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Divisor is held stable by the sequencer for the whole run
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      quotient <= req.dividend;
      cnt      <= '0;
    end else if (running) begin
      rem      <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
      quotient <= {quotient[DIVD_W-2:0], ge};
      cnt      <= cnt + 1'b1;
    end
  end

endmodule

// File: design/task_cpu_share_monitor.sv
// Task CPU share monitor: one record per task, charged on context switches.
// Clear and unused modes answer from idle; a read runs QRY_RD, QRY_OUT; a
// switch runs CHG_RD, CHG_WR (skipped with nothing to charge), NEW_RD, NEW_WR;
// at window end, MAX_TASKS sweeps, each one or two runs (one when the share
// saturates) of the shared 33-step divider. One word in flight at a time.
// Results cannot be stalled: done strobes for one cycle with the word.
// Synchronous reset clears all records (per-task valid bits) and the FSM.
module task_cpu_share_monitor #(
  parameter int unsigned MAX_TASKS   = tcsm_pkg::MAX_TASKS_DEF,
  parameter int unsigned TIMER_WIDTH = tcsm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       mode,
  input  logic                             old_valid,
  input  logic [tcsm_pkg::TASK_W-1:0]      old_task,
  input  logic [tcsm_pkg::TASK_W-1:0]      new_task,
  input  logic [tcsm_pkg::TASK_W-1:0]      target_task,
  input  logic [tcsm_pkg::TVAL_W-1:0]      timer_value,
  input  logic [tcsm_pkg::TICK_W-1:0]      tick_number,
  input  logic [tcsm_pkg::PERIOD_W-1:0]    period_count,
  // result
  output logic                             done,
  output logic [tcsm_pkg::SHARE_W-1:0]     share_percent,
  output logic                             period_done,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcsm_pkg::RELOAD_W-1:0]    cfg_data
);
  import tcsm_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_TASKS);
  // record layout: {start timer value, busy count, share}
  localparam int unsigned REC_W   = TIMER_WIDTH + BUSY_W + SHARE_W;
  localparam int unsigned BUSY_LO = SHARE_W;
  localparam int unsigned START_LO = SHARE_W + BUSY_W;

  localparam logic [1:0] MODE_SWITCH = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RELOAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_CHG_RD   = 12'b0000_0000_0010,
    S_CHG_WR   = 12'b0000_0000_0100,
    S_NEW_RD   = 12'b0000_0000_1000,
    S_NEW_WR   = 12'b0000_0001_0000,
    S_SWP_RD   = 12'b0000_0010_0000,
    S_SWP_LD   = 12'b0000_0100_0000,
    S_SWP_DIV1 = 12'b0000_1000_0000,
    S_SWP_DIV2 = 12'b0001_0000_0000,
    S_SWP_WR   = 12'b0010_0000_0000,
    S_QRY_RD   = 12'b0100_0000_0000,
    S_QRY_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [RELOAD_W-1:0] reload_period;
  logic [WINDOW_W-1:0] share_window_ticks;

  // latched command word
  logic [IDX_W-1:0]       old_idx, new_idx, tgt_idx, sweep_idx;
  logic                   new_ok;
  logic [TIMER_WIDTH-1:0] timer_q;
  logic                   tick_chg;
  logic                   window_hit;
  logic [TICK_W-1:0]      last_switch_tick;
  logic [SHARE_W-1:0]     share_q;

  // record store: data in RAM, valid bits in flops so reset empties it at once
  logic [MAX_TASKS-1:0] rec_valid;
  logic                 rd_valid;
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [REC_W-1:0]     ram_wdata, ram_rdata, rec;

  logic [TIMER_WIDTH-1:0] rec_start;
  logic [BUSY_W-1:0]      rec_busy, busy_chg;
  logic [SHARE_W-1:0]     rec_share;

  // shared divider
  div_req_t            div_req;
  logic                div_done;
  logic [DIVD_W-1:0]   div_quo;
  logic [RELOAD_W-1:0] rel_eff;
  logic [WINDOW_W-1:0] win_eff;
  logic                sat;
  logic [22:0]         q100;

  logic accept;
  logic old_ok_in, new_ok_in, tgt_ok_in;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign old_ok_in = 32'(old_task) < 32'(MAX_TASKS);
  assign new_ok_in = 32'(new_task) < 32'(MAX_TASKS);
  assign tgt_ok_in = 32'(target_task) < 32'(MAX_TASKS);

  // An entry never written since reset or clear reads as all zero
  assign rec       = rd_valid ? ram_rdata : '0;
  assign rec_share = rec[SHARE_W-1:0];
  assign rec_busy  = rec[BUSY_LO +: BUSY_W];
  assign rec_start = rec[START_LO +: TIMER_WIDTH];

  // Charge: elapsed down-count, plus one reload when the tick has moved on
  assign busy_chg = rec_busy + BUSY_W'(rec_start) - BUSY_W'(timer_q)
                    + (tick_chg ? BUSY_W'(reload_period) : '0);

  // Zero divisors count as one
  assign rel_eff = (reload_period == '0) ? RELOAD_W'(1) : reload_period;
  assign win_eff = (share_window_ticks == '0) ? WINDOW_W'(1) : share_window_ticks;

  // q*100/win reaches 100 exactly when q >= win, so only q < win is divided
  assign sat  = div_quo >= DIVD_W'(win_eff);
  assign q100 = 23'(div_quo[WINDOW_W-1:0]) * 23'd100;

  // Hold the reload as divisor for the whole first run, the window after it
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIVD_W'(q100);
    div_req.divisor  = DIVS_W'(win_eff);
    if (state == S_SWP_LD) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIVD_W'(rec_busy) + DIVD_W'(rel_eff >> 1);
      div_req.divisor  = rel_eff;
    end else if (state == S_SWP_DIV1) begin
      div_req.start   = div_done && !sat;
      div_req.divisor = rel_eff;
    end
  end

  // RAM port control per sequencer step
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = old_idx;
    ram_we    = 1'b0;
    ram_waddr = old_idx;
    ram_wdata = {rec_start, busy_chg, rec_share};
    unique case (state)
      S_CHG_RD: begin
        ram_re = 1'b1;
      end
      S_CHG_WR: begin
        ram_we = 1'b1;
      end
      S_NEW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = new_idx;
      end
      S_NEW_WR: begin
        ram_we    = new_ok;
        ram_waddr = new_idx;
        ram_wdata = {timer_q, rec_busy, rec_share};
      end
      S_SWP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = sweep_idx;
      end
      S_SWP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_idx;
        ram_wdata = {rec_start, BUSY_W'(0), share_q};
      end
      S_QRY_RD: begin
        ram_re    = 1'b1;
        ram_raddr = tgt_idx;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_period      <= RELOAD_W'(72000);
      share_window_ticks <= WINDOW_W'(1000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RELOAD: reload_period      <= cfg_data;
        CFG_WINDOW: share_window_ticks <= cfg_data[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      share_percent    <= '0;
      period_done      <= 1'b0;
      rec_valid        <= '0;
      rd_valid         <= 1'b0;
      last_switch_tick <= '0;
    end else begin
      done <= 1'b0;
      if (ram_re) begin
        rd_valid <= rec_valid[ram_raddr];
      end
      if (ram_we) begin
        rec_valid[ram_waddr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (mode)
              MODE_SWITCH: begin
                last_switch_tick <= tick_number;
                state <= (old_valid && old_ok_in) ? S_CHG_RD : S_NEW_RD;
              end
              MODE_READ: begin
                if (tgt_ok_in) begin
                  state <= S_QRY_RD;
                end else begin
                  done          <= 1'b1;
                  share_percent <= '0;
                  period_done   <= 1'b0;
                end
              end
              MODE_CLEAR: begin
                // drop the record: an invalid entry reads as zero
                if (tgt_ok_in) begin
                  rec_valid[IDX_W'(target_task)] <= 1'b0;
                end
                done          <= 1'b1;
                share_percent <= '0;
                period_done   <= 1'b0;
              end
              default: begin
                done          <= 1'b1;
                share_percent <= '0;
                period_done   <= 1'b0;
              end
            endcase
          end
        end
        S_CHG_RD:   state <= S_CHG_WR;
        S_CHG_WR:   state <= S_NEW_RD;
        S_NEW_RD:   state <= S_NEW_WR;
        S_NEW_WR: begin
          if (window_hit) begin
            state <= S_SWP_RD;
          end else begin
            state         <= S_IDLE;
            done          <= 1'b1;
            share_percent <= '0;
            period_done   <= 1'b0;
          end
        end
        S_SWP_RD:   state <= S_SWP_LD;
        S_SWP_LD:   state <= S_SWP_DIV1;
        S_SWP_DIV1: begin
          if (div_done) begin
            state <= sat ? S_SWP_WR : S_SWP_DIV2;
          end
        end
        S_SWP_DIV2: begin
          if (div_done) begin
            state <= S_SWP_WR;
          end
        end
        S_SWP_WR: begin
          if (sweep_idx == IDX_W'(MAX_TASKS - 1)) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            share_percent <= '0;
            period_done   <= 1'b1;
          end else begin
            state <= S_SWP_RD;
          end
        end
        S_QRY_RD:   state <= S_QRY_OUT;
        S_QRY_OUT: begin
          state         <= S_IDLE;
          done          <= 1'b1;
          share_percent <= rec_share;
          period_done   <= 1'b0;
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

  // Command word capture and sweep datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      old_idx    <= IDX_W'(old_task);
      new_idx    <= IDX_W'(new_task);
      tgt_idx    <= IDX_W'(target_task);
      new_ok     <= new_ok_in;
      timer_q    <= TIMER_WIDTH'(timer_value);
      tick_chg   <= tick_number != last_switch_tick;
      window_hit <= period_count == share_window_ticks;
      sweep_idx  <= '0;
    end else if (state == S_SWP_WR) begin
      sweep_idx <= sweep_idx + 1'b1;
    end
    if (state == S_SWP_DIV1 && div_done && sat) begin
      share_q <= PCT_FULL;
    end else if (state == S_SWP_DIV2 && div_done) begin
      share_q <= div_quo[SHARE_W-1:0];
    end
  end

  tcsm_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_TASKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for task_cpu_share_monitor: directed and random
// command words, scored against a behavioural model of the task table.
// Depends on tcsm_pkg and the task_cpu_share_monitor RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcsm_pkg::*;

  // Command codes carried on the mode port
  typedef enum logic [1:0] {
    MODE_SWITCH = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } cmd_mode_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned WORDS_PER_PHASE = 125;
  localparam int unsigned TASKS           = MAX_TASKS_DEF;

  // One command word as it stands on the input ports
  typedef struct {
    cmd_mode_e            mode;
    logic                 old_valid;
    logic [TASK_W-1:0]    old_task;
    logic [TASK_W-1:0]    new_task;
    logic [TASK_W-1:0]    target_task;
    logic [TVAL_W-1:0]    timer_value;
    logic [TICK_W-1:0]    tick_number;
    logic [PERIOD_W-1:0]  period_count;
  } cpu_cmd_t;

  // One result word
  typedef struct {
    bit [SHARE_W-1:0] share;
    bit               period_done;
  } share_word_t;

  // Task table model plus the queue of result words still to come
  class share_scoreboard;
    bit [RELOAD_W-1:0] reload;
    bit [WINDOW_W-1:0] window;
    bit [TICK_W-1:0]   last_tick;
    bit [TVAL_W-1:0]   start_val [TASKS];
    bit [BUSY_W-1:0]   busy_cnt  [TASKS];
    bit [SHARE_W-1:0]  share     [TASKS];
    share_word_t       awaited_q [$];
    int unsigned       failures;

    function new();
      reload    = 25'd72000;
      window    = 16'd1000;
      last_tick = '0;
      failures  = 0;
      for (int i = 0; i < TASKS; i++) begin
        start_val[i] = '0;
        busy_cnt[i]  = '0;
        share[i]     = '0;
      end
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [RELOAD_W-1:0] data);
      if (idx == REG_RELOAD) begin
        reload = data;
      end else begin
        window = data[WINDOW_W-1:0];
      end
    endfunction

    // Work out the result word of an accepted command and update the table
    function void note_command(cpu_cmd_t c);
      share_word_t      w;
      bit [BUSY_W-1:0]  delta;
      longint unsigned  rel;
      longint unsigned  win;
      longint unsigned  q;
      longint unsigned  s;
      w.share       = '0;
      w.period_done = 1'b0;
      case (c.mode)
        MODE_SWITCH: begin
          // charge the outgoing task; a changed tick means one timer reload
          if (c.old_valid) begin
            delta = BUSY_W'(start_val[c.old_task]) - BUSY_W'(c.timer_value);
            if (last_tick != c.tick_number) delta += BUSY_W'(reload);
            busy_cnt[c.old_task] += delta;
          end
          last_tick = c.tick_number;
          start_val[c.new_task] = c.timer_value;
          if (c.period_count == window) begin
            // zero divisors count as one
            rel = (reload == 0) ? 1 : reload;
            win = (window == 0) ? 1 : window;
            for (int i = 0; i < TASKS; i++) begin
              q = (longint'(busy_cnt[i]) + rel / 2) / rel;
              s = q * 100 / win;
              share[i]    = (s > 100) ? SHARE_W'(100) : SHARE_W'(s);
              busy_cnt[i] = '0;
            end
            w.period_done = 1'b1;
          end
        end
        MODE_READ: w.share = share[c.target_task];
        MODE_CLEAR: begin
          start_val[c.target_task] = '0;
          busy_cnt[c.target_task]  = '0;
          share[c.target_task]     = '0;
        end
        default: ;
      endcase
      awaited_q.push_back(w);
    endfunction

    function void check_result(bit [SHARE_W-1:0] got_share, bit got_done);
      share_word_t w;
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result word: share %0d period_done %0d",
                 $realtime, got_share, got_done);
        failures++;
        return;
      end
      w = awaited_q.pop_front();
      if (got_share != w.share) begin
        $display("%0t: share_percent mismatch: expected %0d, actual %0d",
                 $realtime, w.share, got_share);
        failures++;
      end
      if (got_done != w.period_done) begin
        $display("%0t: period_done mismatch: expected %0d, actual %0d",
                 $realtime, w.period_done, got_done);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           mode = '0;
  logic                 old_valid = 1'b0;
  logic [TASK_W-1:0]    old_task = '0;
  logic [TASK_W-1:0]    new_task = '0;
  logic [TASK_W-1:0]    target_task = '0;
  logic [TVAL_W-1:0]    timer_value = '0;
  logic [TICK_W-1:0]    tick_number = '0;
  logic [PERIOD_W-1:0]  period_count = '0;
  logic                 done;
  logic [SHARE_W-1:0]   share_percent;
  logic                 period_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RELOAD_W-1:0]  cfg_data = '0;

  share_scoreboard sb;

  // State of the well-formed switch sequence: running task, tick, timer
  int unsigned          gen_task;
  bit                   gen_running;
  logic [TICK_W-1:0]    gen_tick;
  int unsigned          gen_timer;
  int unsigned          gen_ticks_in_win;

  task_cpu_share_monitor dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .old_valid     (old_valid),
    .old_task      (old_task),
    .new_task      (new_task),
    .target_task   (target_task),
    .timer_value   (timer_value),
    .tick_number   (tick_number),
    .period_count  (period_count),
    .done          (done),
    .share_percent (share_percent),
    .period_done   (period_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Monitor: sample every handshake on the rising edge, before the block's
  // own updates land, and feed the scoreboard in edge order.
  always @(posedge clk) begin
    cpu_cmd_t c;
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
      if (start && !busy) begin
        c.mode         = cmd_mode_e'(mode);
        c.old_valid    = old_valid;
        c.old_task     = old_task;
        c.new_task     = new_task;
        c.target_task  = target_task;
        c.timer_value  = timer_value;
        c.tick_number  = tick_number;
        c.period_count = period_count;
        sb.note_command(c);
      end
      if (done) sb.check_result(share_percent, period_done);
    end
  end

  function automatic cpu_cmd_t make_cmd(cmd_mode_e m, logic ov, int unsigned ot,
                                        int unsigned nt, int unsigned tt,
                                        logic [TVAL_W-1:0] tv, logic [TICK_W-1:0] tk,
                                        logic [PERIOD_W-1:0] pc);
    cpu_cmd_t c;
    c.mode         = m;
    c.old_valid    = ov;
    c.old_task     = TASK_W'(ot);
    c.new_task     = TASK_W'(nt);
    c.target_task  = TASK_W'(tt);
    c.timer_value  = tv;
    c.tick_number  = tk;
    c.period_count = pc;
    return c;
  endfunction

  // Draw the next random word. Most are switches that follow a plausible
  // schedule (chained tasks, a timer that counts down, ticks that advance
  // by one); the rest are reads, clears, the unused code and plain noise.
  function automatic cpu_cmd_t next_cmd();
    cpu_cmd_t        c;
    int unsigned     pick;
    longint unsigned tmax;
    pick = $urandom_range(0, 99);
    tmax = (sb.reload == 0) ? 0 : longint'(sb.reload) - 1;
    if (tmax > 24'hFFFFFF) tmax = 24'hFFFFFF;
    c = make_cmd(MODE_READ, 1'($urandom), $urandom, $urandom, $urandom,
                 TVAL_W'($urandom), $urandom, PERIOD_W'($urandom));
    if (pick < 5) begin
      // noise: any code, any fields
      c.mode = cmd_mode_e'($urandom_range(0, 3));
    end else if (pick < 8) begin
      c.mode = MODE_UNUSED;
    end else if (pick < 22) begin
      c.mode = MODE_READ;
    end else if (pick < 28) begin
      c.mode = MODE_CLEAR;
    end else begin
      // broken schedule now and then: skip several ticks at once
      if (pick < 33) gen_tick += $urandom_range(2, 1000);
      if ($urandom_range(0, 99) < 30) begin
        gen_tick++;
        gen_ticks_in_win++;
        gen_timer = $urandom_range(0, int'(tmax));
      end else begin
        gen_timer = $urandom_range(0, gen_timer);
      end
      c.mode        = MODE_SWITCH;
      c.old_valid   = ($urandom_range(0, 19) == 0) ? !gen_running : gen_running;
      c.old_task    = TASK_W'(gen_task);
      c.new_task    = TASK_W'($urandom);
      c.timer_value = TVAL_W'(gen_timer);
      c.tick_number = gen_tick;
      gen_task      = c.new_task;
      gen_running   = 1'b1;
      if ($urandom_range(0, 99) < 10) begin
        c.period_count   = sb.window;
        gen_ticks_in_win = 0;
      end else if (sb.window == 0) begin
        c.period_count = PERIOD_W'($urandom_range(1, 65535));
      end else begin
        c.period_count = PERIOD_W'(gen_ticks_in_win % sb.window);
      end
    end
    return c;
  endfunction

  // Present a word and hold it until the block takes it; start stays high
  task automatic send_word(cpu_cmd_t c);
    start        <= 1'b1;
    mode         <= c.mode;
    old_valid    <= c.old_valid;
    old_task     <= c.old_task;
    new_task     <= c.new_task;
    target_task  <= c.target_task;
    timer_value  <= c.timer_value;
    tick_number  <= c.tick_number;
    period_count <= c.period_count;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that a second write can follow directly
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RELOAD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [RELOAD_W-1:0] rel, logic [WINDOW_W-1:0] win);
    write_reg(REG_RELOAD, rel);
    write_reg(REG_WINDOW, RELOAD_W'(win));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned         idle_pct;
    int unsigned         max_gap;
    int unsigned         taken;
    logic [RELOAD_W-1:0] rel;
    logic [WINDOW_W-1:0] win;
    cpu_cmd_t            c;

    sb = new();
    gen_task         = 0;
    gen_running      = 1'b0;
    gen_tick         = $urandom;
    gen_timer        = 0;
    gen_ticks_in_win = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration (reload 72000, window 1000)
    send_word(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
    // first switch-in with nothing to charge, timer at full scale
    send_word(make_cmd(MODE_SWITCH, 0, 0, 0, 0, 24'hFFFFFF, 0, 0));
    // tick changed: charge with one reload, all-ones tick and period
    send_word(make_cmd(MODE_SWITCH, 1, 0, 15, 15, 0, 32'hFFFFFFFF, 16'hFFFF));
    // same tick, period reaches the window: shares recomputed
    send_word(make_cmd(MODE_SWITCH, 1, 15, 5, 0, 0, 32'hFFFFFFFF, 16'd1000));
    send_word(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(MODE_READ, 1, 15, 15, 15, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF));
    // timer above the saved start in the same tick: the count wraps
    send_word(make_cmd(MODE_SWITCH, 1, 5, 10, 0, 24'hFFFFFF, 32'hFFFFFFFF, 16'd999));
    // window end with no outgoing task; the wrapped count saturates at 100
    send_word(make_cmd(MODE_SWITCH, 0, 15, 0, 0, 24'h123456, 32'd1, 16'd1000));
    send_word(make_cmd(MODE_READ, 0, 0, 0, 5, 0, 0, 0));
    send_word(make_cmd(MODE_READ, 0, 0, 0, 10, 0, 0, 0));
    // unused code: no effect, zero result
    send_word(make_cmd(MODE_UNUSED, 1, 15, 15, 15, 24'hFFFFFF, 32'hFFFFFFFF, 16'd1000));
    send_word(make_cmd(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_cmd(MODE_READ, 0, 0, 0, 5, 0, 0, 0));
    // clear a saturated record, then read it back
    send_word(make_cmd(MODE_CLEAR, 1, 15, 15, 5, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF));
    send_word(make_cmd(MODE_READ, 0, 0, 0, 5, 0, 0, 0));
    send_word(make_cmd(MODE_CLEAR, 0, 0, 0, 15, 0, 0, 0));
    send_word(make_cmd(MODE_SWITCH, 1, 0, 15, 0, 24'h000001, 32'd1, 16'd1000));
    send_word(make_cmd(MODE_READ, 0, 0, 0, 15, 0, 0, 0));
    send_word(make_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0));

    // Random part: one setting per phase, extremes and zero divisors among
    // them; the sender idles rarely, then often, then not at all.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin rel = 25'd1000;       win = 16'd8;     end
        1: begin rel = 25'd0;          win = 16'd0;     end
        2: begin rel = 25'd16777216;   win = 16'hFFFF;  end
        3: begin rel = 25'd1;          win = 16'd1;     end
        4: begin rel = 25'h1FFFFFF;    win = 16'd3;     end
        5: begin rel = 25'd72000;      win = 16'd10;    end
        6: begin
          rel = RELOAD_W'($urandom_range(1, 100000));
          win = WINDOW_W'($urandom_range(1, 50));
        end
        default: begin rel = 25'd500;  win = 16'd2;     end
      endcase
      idle_pct = (p < 3) ? 6 : (p < 6) ? 47 : 0;
      max_gap  = (p < 3) ? 4 : 8;

      // drop start and let every result arrive before touching the registers
      start <= 1'b0;
      wait_drained();
      set_config(rel, win);

      taken = 0;
      while (taken < WORDS_PER_PHASE) begin
        c = next_cmd();
        send_word(c);
        if (c.mode != MODE_UNUSED) taken++;
        if ($urandom_range(0, 99) < idle_pct) sender_gap($urandom_range(1, max_gap));
      end
    end

    start <= 1'b0;
    wait_drained();
    // hold a little longer to catch any stray result word
    repeat (64) @(posedge clk);
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
design/tcsm_pkg.sv
design/tcsm_ram.sv
design/tcsm_div.sv
design/task_cpu_share_monitor.sv
tb/testbench.sv
